[hw/rtl/assert_macros.svh]
// Assertion macros shared by the suffix array RTL.
// Simulation gets concurrent assertions; synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SALCP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SALCP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SALCP_ASSERT(label, clk, rst_n, prop, msg)
`define SALCP_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[hw/rtl/salcp_pkg.sv]
// Package for the suffix array and LCP core: item types and constants.
// Used by suffix_array_with_lcp_core; depends on nothing.
`default_nettype none
package salcp_pkg;

    localparam int MAX_LEN_DEF = 1024;
    localparam int SYM_W       = 8;
    localparam int RANK_W      = 10;
    localparam int POS_W       = 10;
    localparam int LCP_W       = 12;
    localparam int FIRST_KEYS  = 257;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [SYM_W-1:0]  symbol;
        logic              last;
        logic [RANK_W-1:0] rank;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]        position;
        logic signed [LCP_W-1:0] common_prefix;
        logic                    in_range;
    } t_out_item;

endpackage
`default_nettype wire

[hw/rtl/suffix_array_with_lcp_core.sv]
// Suffix array and LCP core: loader, prefix-doubling sequencer, Kasai LCP, reader.
// Depends on salcp_pkg and assert_macros.svh.
//
// Load items (mode 0) each append a symbol; symbols past
// MAX_LEN are dropped. The item marked last starts the build, during which
// i_in is not ready. The build is a sequencer over single-read, single-write
// memories with registered read data, one element step at a time, so its
// length is set by memory accesses: with n = len + 1 it runs the first sort,
// ceil(log2 n) doubling passes, the sentinel drop and rank table, and the
// LCP scan, which visits each position and compares symbols up to a mismatch.
// A read item (mode 1) passes through S_RD0 and S_RD1 to the output register,
// which holds it while the consumer stalls; out-of-range ranks return zeros
// with in_range low. Results of a build stay readable until the next build.
`default_nettype none
`include "assert_macros.svh"
module suffix_array_with_lcp_core
    import salcp_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out
);

    localparam int NODES = MAX_LEN + 1;
    localparam int NW    = $clog2(NODES);
    localparam int VW    = $clog2(MAX_LEN + 2);
    localparam int TW    = $clog2(MAX_LEN);
    localparam int CD    = (NODES > FIRST_KEYS) ? NODES : FIRST_KEYS;
    localparam int CW    = $clog2(CD);
    localparam int IW    = $clog2(CD + 1);
    localparam int SW    = VW + 1;
    localparam int LW    = VW + 1;
    localparam int KW    = IW + 1;

    typedef enum logic [5:0] {
        S_IDLE, S_RD0, S_RD1,
        S_CLR, S_CNT0, S_CNT1, S_CNT2, S_PFX0, S_PFX1,
        S_PLC0, S_PLC1, S_PLC2, S_PLC3,
        S_CLS0, S_CLS1, S_CLS2,
        S_CPY0, S_CPY1, S_REN0, S_REN1, S_REN2, S_REN3, S_CPC0, S_CPC1,
        S_DRP0, S_DRP1, S_RNK0, S_RNK1,
        S_LCP0, S_LCP1, S_LCP2, S_LCP3, S_LCP4, S_LCP5
    } t_state;

    // Memories and their registered read data
    logic [SYM_W-1:0]     r_text_mem [MAX_LEN];
    logic [VW-1:0]        r_sa_mem   [NODES];
    logic [VW-1:0]        r_cls_mem  [NODES];
    logic [VW-1:0]        r_tmp_mem  [NODES];
    logic [VW-1:0]        r_cnt_mem  [CD];
    logic [TW-1:0]        r_rnk_mem  [MAX_LEN];
    logic signed [LW-1:0] r_lcp_mem  [MAX_LEN];

    logic [SYM_W-1:0]     r_text_q;
    logic [VW-1:0]        r_sa_q, r_cls_q, r_tmp_q, r_cnt_q;
    logic [TW-1:0]        r_rnk_q;
    logic signed [LW-1:0] r_lcp_q;

    // Memory port controls
    logic                 text_we, sa_we, cls_we, tmp_we, cnt_we, rnk_we, lcp_we;
    logic [TW-1:0]        text_wa, text_ra, rnk_wa, rnk_ra, lcp_wa, lcp_ra;
    logic [NW-1:0]        sa_wa, sa_ra, cls_wa, cls_ra, tmp_wa, tmp_ra;
    logic [CW-1:0]        cnt_wa, cnt_ra;
    logic [SYM_W-1:0]     text_wd;
    logic [VW-1:0]        sa_wd, cls_wd, tmp_wd, cnt_wd;
    logic [TW-1:0]        rnk_wd;
    logic signed [LW-1:0] lcp_wd;

    // Control registers
    t_state          r_state, n_state;
    logic [VW-1:0]   r_len, n_len, r_built, n_built;
    logic            r_fresh, n_fresh, r_first, n_first;
    logic [IW-1:0]   r_i, n_i;
    logic [VW-1:0]   r_w, n_w, r_sum, n_sum, r_k, n_k;
    logic [SW-1:0]   r_step, n_step;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic [CW-1:0]   r_key, n_key, r_pkey, n_pkey;
    logic [VW-1:0]   r_p, n_p, r_a, n_a, r_j, n_j;
    logic [VW-1:0]   r_pcls, n_pcls, r_ca, n_ca, r_pca, n_pca, r_pca2, n_pca2;
    logic [TW-1:0]   r_r, n_r;
    logic [SYM_W-1:0] r_ti, n_ti;

    // Derived values
    logic [VW-1:0]   w_n, w_el, w_p, w_a2, w_newc, w_newr, w_kdec;
    logic [IW-1:0]   w_lim_last, w_n_last, w_len_last;
    logic [CW-1:0]   w_fkey, w_akey;
    logic [SW-1:0]   w_sum_p, w_sum_a2, w_step2;
    logic [KW-1:0]   w_ik, w_jk;
    logic            w_hit;

    assign w_n        = r_len + VW'(1);
    assign w_el       = r_fresh ? '0 : r_len;
    assign w_n_last   = IW'(w_n) - IW'(1);
    assign w_len_last = IW'(r_len) - IW'(1);
    assign w_lim_last = r_first ? IW'(FIRST_KEYS - 1) : w_n_last;
    assign w_fkey     = (r_i < IW'(r_len)) ? CW'(r_text_q) + CW'(1) : '0;
    assign w_akey     = (r_a < r_len) ? CW'(r_text_q) + CW'(1) : '0;
    assign w_sum_p    = SW'(r_sa_q) + SW'(w_n) - r_step;
    assign w_p        = (SW'(r_sa_q) >= r_step) ? VW'(SW'(r_sa_q) - r_step) : VW'(w_sum_p);
    assign w_sum_a2   = SW'(r_a) + r_step;
    assign w_a2       = (w_sum_a2 >= SW'(w_n)) ? VW'(w_sum_a2 - SW'(w_n)) : VW'(w_sum_a2);
    assign w_step2    = r_step << 1;
    assign w_newc     = (r_i == '0) ? '0 : r_pcls + VW'(w_akey != r_pkey);
    assign w_newr     = (r_i == '0) ? '0 :
                        r_pcls + VW'(!(r_ca == r_pca && r_cls_q == r_pca2));
    assign w_kdec     = (r_k != '0) ? r_k - VW'(1) : '0;
    assign w_ik       = KW'(r_i) + KW'(r_k);
    assign w_jk       = KW'(r_j) + KW'(r_k);
    assign w_hit      = (32'(r_rank) < 32'(r_built));

    // Sequencer: next state, register updates and memory port selection
    always_comb begin
        n_state = r_state;     n_len = r_len;       n_built = r_built;
        n_fresh = r_fresh;     n_first = r_first;   n_i = r_i;
        n_w = r_w;             n_sum = r_sum;       n_k = r_k;
        n_step = r_step;       n_rank = r_rank;     n_key = r_key;
        n_pkey = r_pkey;       n_p = r_p;           n_a = r_a;
        n_j = r_j;             n_pcls = r_pcls;     n_ca = r_ca;
        n_pca = r_pca;         n_pca2 = r_pca2;     n_r = r_r;
        n_ti = r_ti;           n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        text_we = 1'b0; text_wa = '0; text_wd = '0; text_ra = '0;
        sa_we = 1'b0;   sa_wa = '0;   sa_wd = '0;   sa_ra = '0;
        cls_we = 1'b0;  cls_wa = '0;  cls_wd = '0;  cls_ra = '0;
        tmp_we = 1'b0;  tmp_wa = '0;  tmp_wd = '0;  tmp_ra = '0;
        cnt_we = 1'b0;  cnt_wa = '0;  cnt_wd = '0;  cnt_ra = '0;
        rnk_we = 1'b0;  rnk_wa = '0;  rnk_wd = '0;  rnk_ra = '0;
        lcp_we = 1'b0;  lcp_wa = '0;  lcp_wd = '0;  lcp_ra = '0;

        case (r_state)
            // Take load and read items
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in.mode == MODE_LOAD) begin
                        n_fresh = 1'b0;
                        n_len   = w_el;
                        if (w_el < VW'(MAX_LEN)) begin
                            text_we = 1'b1;
                            text_wa = w_el[TW-1:0];
                            text_wd = i_in.symbol;
                            n_len   = w_el + VW'(1);
                        end
                        if (i_in.last) begin
                            n_fresh = 1'b1;
                            n_first = 1'b1;
                            n_i     = '0;
                            n_state = S_CLR;
                        end
                    end else begin
                        n_rank  = i_in.rank;
                        n_state = S_RD0;
                    end
                end
            end
            S_RD0: begin
                sa_ra   = NW'(r_rank);
                lcp_ra  = TW'(r_rank);
                n_state = S_RD1;
            end
            // Hold read addresses until the output register is free
            S_RD1: begin
                sa_ra  = NW'(r_rank);
                lcp_ra = TW'(r_rank);
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    if (w_hit) begin
                        n_out.position      = POS_W'(r_sa_q);
                        n_out.common_prefix = LCP_W'(r_lcp_q);
                        n_out.in_range      = 1'b1;
                    end else begin
                        n_out = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            // Clear buckets
            S_CLR: begin
                cnt_we = 1'b1;
                cnt_wa = r_i[CW-1:0];
                if (r_i == w_lim_last) begin
                    n_i = '0;
                    n_state = S_CNT0;
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            // Count keys
            S_CNT0: begin
                text_ra = r_i[TW-1:0];
                cls_ra  = r_i[NW-1:0];
                n_state = S_CNT1;
            end
            S_CNT1: begin
                n_key   = r_first ? w_fkey : CW'(r_cls_q);
                cnt_ra  = n_key;
                n_state = S_CNT2;
            end
            S_CNT2: begin
                cnt_we = 1'b1;
                cnt_wa = r_key;
                cnt_wd = r_cnt_q + VW'(1);
                if (r_i == w_n_last) begin
                    n_i = '0;
                    n_sum = '0;
                    n_state = S_PFX0;
                end else begin
                    n_i = r_i + IW'(1);
                    n_state = S_CNT0;
                end
            end
            // Turn counts into bucket starts
            S_PFX0: begin
                cnt_ra  = r_i[CW-1:0];
                n_state = S_PFX1;
            end
            S_PFX1: begin
                cnt_we = 1'b1;
                cnt_wa = r_i[CW-1:0];
                cnt_wd = r_sum;
                n_sum  = r_sum + r_cnt_q;
                if (r_i == w_lim_last) begin
                    n_i = '0;
                    n_state = S_PLC0;
                end else begin
                    n_i = r_i + IW'(1);
                    n_state = S_PFX0;
                end
            end
            // Place each element into its bucket
            S_PLC0: begin
                text_ra = r_i[TW-1:0];
                sa_ra   = r_i[NW-1:0];
                n_state = S_PLC1;
            end
            S_PLC1: begin
                if (r_first) begin
                    n_key   = w_fkey;
                    cnt_ra  = w_fkey;
                    n_p     = VW'(r_i);
                    n_state = S_PLC3;
                end else begin
                    n_p     = w_p;
                    cls_ra  = w_p[NW-1:0];
                    n_state = S_PLC2;
                end
            end
            S_PLC2: begin
                n_key   = CW'(r_cls_q);
                cnt_ra  = CW'(r_cls_q);
                n_state = S_PLC3;
            end
            S_PLC3: begin
                cnt_we = 1'b1;
                cnt_wa = r_key;
                cnt_wd = r_cnt_q + VW'(1);
                if (r_first) begin
                    sa_we = 1'b1;
                    sa_wa = r_cnt_q[NW-1:0];
                    sa_wd = r_p;
                end else begin
                    tmp_we = 1'b1;
                    tmp_wa = r_cnt_q[NW-1:0];
                    tmp_wd = r_p;
                end
                if (r_i == w_n_last) begin
                    n_i = '0;
                    n_state = r_first ? S_CLS0 : S_CPY0;
                end else begin
                    n_i = r_i + IW'(1);
                    n_state = S_PLC0;
                end
            end
            // Initial classes from single symbols
            S_CLS0: begin
                sa_ra   = r_i[NW-1:0];
                n_state = S_CLS1;
            end
            S_CLS1: begin
                n_a     = r_sa_q;
                text_ra = r_sa_q[TW-1:0];
                n_state = S_CLS2;
            end
            S_CLS2: begin
                cls_we = 1'b1;
                cls_wa = r_a[NW-1:0];
                cls_wd = w_newc;
                n_pcls = w_newc;
                n_pkey = w_akey;
                if (r_i == w_n_last) begin
                    n_i     = '0;
                    n_first = 1'b0;
                    n_step  = SW'(1);
                    n_w     = '0;
                    n_state = (SW'(1) < SW'(w_n)) ? S_CLR : S_DRP0;
                end else begin
                    n_i = r_i + IW'(1);
                    n_state = S_CLS0;
                end
            end
            // Copy sorted order back
            S_CPY0: begin
                tmp_ra  = r_i[NW-1:0];
                n_state = S_CPY1;
            end
            S_CPY1: begin
                sa_we = 1'b1;
                sa_wa = r_i[NW-1:0];
                sa_wd = r_tmp_q;
                if (r_i == w_n_last) begin
                    n_i = '0;
                    n_state = S_REN0;
                end else begin
                    n_i = r_i + IW'(1);
                    n_state = S_CPY0;
                end
            end
            // Renumber classes on (class, class at +step)
            S_REN0: begin
                sa_ra   = r_i[NW-1:0];
                n_state = S_REN1;
            end
            S_REN1: begin
                n_a     = r_sa_q;
                cls_ra  = r_sa_q[NW-1:0];
                n_state = S_REN2;
            end
            S_REN2: begin
                n_ca    = r_cls_q;
                cls_ra  = w_a2[NW-1:0];
                n_state = S_REN3;
            end
            S_REN3: begin
                tmp_we = 1'b1;
                tmp_wa = r_a[NW-1:0];
                tmp_wd = w_newr;
                n_pcls = w_newr;
                n_pca  = r_ca;
                n_pca2 = r_cls_q;
                if (r_i == w_n_last) begin
                    n_i = '0;
                    n_state = S_CPC0;
                end else begin
                    n_i = r_i + IW'(1);
                    n_state = S_REN0;
                end
            end
            // Copy new classes back, then double the step
            S_CPC0: begin
                tmp_ra  = r_i[NW-1:0];
                n_state = S_CPC1;
            end
            S_CPC1: begin
                cls_we = 1'b1;
                cls_wa = r_i[NW-1:0];
                cls_wd = r_tmp_q;
                if (r_i == w_n_last) begin
                    n_i    = '0;
                    n_w    = '0;
                    n_step = w_step2;
                    n_state = (w_step2 < SW'(w_n)) ? S_CLR : S_DRP0;
                end else begin
                    n_i = r_i + IW'(1);
                    n_state = S_CPC0;
                end
            end
            // Drop the sentinel suffix
            S_DRP0: begin
                sa_ra   = r_i[NW-1:0];
                n_state = S_DRP1;
            end
            S_DRP1: begin
                if (r_sa_q != r_len) begin
                    sa_we = 1'b1;
                    sa_wa = r_w[NW-1:0];
                    sa_wd = r_sa_q;
                    n_w   = r_w + VW'(1);
                end
                if (r_i == w_n_last) begin
                    n_i = '0;
                    n_state = S_RNK0;
                end else begin
                    n_i = r_i + IW'(1);
                    n_state = S_DRP0;
                end
            end
            // Build rank of each position
            S_RNK0: begin
                sa_ra   = r_i[NW-1:0];
                n_state = S_RNK1;
            end
            S_RNK1: begin
                rnk_we = 1'b1;
                rnk_wa = r_sa_q[TW-1:0];
                rnk_wd = TW'(r_i);
                if (r_i == w_len_last) begin
                    n_i = '0;
                    n_k = '0;
                    n_state = S_LCP0;
                end else begin
                    n_i = r_i + IW'(1);
                    n_state = S_RNK0;
                end
            end
            // Kasai scan over positions
            S_LCP0: begin
                rnk_ra  = r_i[TW-1:0];
                n_state = S_LCP1;
            end
            S_LCP1: begin
                n_r = r_rnk_q;
                if (VW'(r_rnk_q) + VW'(1) >= r_len) begin
                    lcp_we = 1'b1;
                    lcp_wa = r_rnk_q;
                    lcp_wd = '1;
                    n_k    = '0;
                    if (r_i == w_len_last) begin
                        n_built = r_len;
                        n_state = S_IDLE;
                    end else begin
                        n_i = r_i + IW'(1);
                        n_state = S_LCP0;
                    end
                end else begin
                    sa_ra   = NW'(r_rnk_q) + NW'(1);
                    n_state = S_LCP2;
                end
            end
            S_LCP2: begin
                n_j     = r_sa_q;
                n_state = S_LCP3;
            end
            S_LCP3: begin
                if (w_ik < KW'(r_len) && w_jk < KW'(r_len)) begin
                    text_ra = w_ik[TW-1:0];
                    n_state = S_LCP4;
                end else begin
                    lcp_we = 1'b1;
                    lcp_wa = r_r;
                    lcp_wd = LW'(r_k);
                    n_k    = w_kdec;
                    if (r_i == w_len_last) begin
                        n_built = r_len;
                        n_state = S_IDLE;
                    end else begin
                        n_i = r_i + IW'(1);
                        n_state = S_LCP0;
                    end
                end
            end
            S_LCP4: begin
                n_ti    = r_text_q;
                text_ra = w_jk[TW-1:0];
                n_state = S_LCP5;
            end
            S_LCP5: begin
                if (r_ti == r_text_q) begin
                    n_k = r_k + VW'(1);
                    n_state = S_LCP3;
                end else begin
                    lcp_we = 1'b1;
                    lcp_wa = r_r;
                    lcp_wd = LW'(r_k);
                    n_k    = w_kdec;
                    if (r_i == w_len_last) begin
                        n_built = r_len;
                        n_state = S_IDLE;
                    end else begin
                        n_i = r_i + IW'(1);
                        n_state = S_LCP0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_built     <= '0;
            r_fresh     <= 1'b1;
            r_first     <= 1'b0;
            r_i         <= '0;
            r_w         <= '0;
            r_sum       <= '0;
            r_k         <= '0;
            r_step      <= SW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_built     <= n_built;
            r_fresh     <= n_fresh;
            r_first     <= n_first;
            r_i         <= n_i;
            r_w         <= n_w;
            r_sum       <= n_sum;
            r_k         <= n_k;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_out  <= n_out;
        r_rank <= n_rank;
        r_key  <= n_key;
        r_pkey <= n_pkey;
        r_p    <= n_p;
        r_a    <= n_a;
        r_j    <= n_j;
        r_pcls <= n_pcls;
        r_ca   <= n_ca;
        r_pca  <= n_pca;
        r_pca2 <= n_pca2;
        r_r    <= n_r;
        r_ti   <= n_ti;
    end

    // Memories: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (text_we) begin
            r_text_mem[text_wa] <= text_wd;
        end
        r_text_q <= r_text_mem[text_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sa_we) begin
            r_sa_mem[sa_wa] <= sa_wd;
        end
        r_sa_q <= r_sa_mem[sa_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cls_we) begin
            r_cls_mem[cls_wa] <= cls_wd;
        end
        r_cls_q <= r_cls_mem[cls_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tmp_we) begin
            r_tmp_mem[tmp_wa] <= tmp_wd;
        end
        r_tmp_q <= r_tmp_mem[tmp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_wa] <= cnt_wd;
        end
        r_cnt_q <= r_cnt_mem[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rnk_we) begin
            r_rnk_mem[rnk_wa] <= rnk_wd;
        end
        r_rnk_q <= r_rnk_mem[rnk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lcp_we) begin
            r_lcp_mem[lcp_wa] <= lcp_wd;
        end
        r_lcp_q <= r_lcp_mem[lcp_ra];
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks
    `SALCP_ASSERT_NEVER(a_len_bound, i_clk, i_rst_n, r_len > VW'(MAX_LEN), "length above maximum")
    `SALCP_ASSERT(a_step_pow2, i_clk, i_rst_n, $onehot(r_step), "doubling step not a power of two")
    `SALCP_ASSERT(a_miss_zero, i_clk, i_rst_n, (r_out_valid && !r_out.in_range) |-> (r_out.position == '0 && r_out.common_prefix == '0), "out-of-range item not zero")
    `SALCP_ASSERT(a_rd_issue, i_clk, i_rst_n, (r_state == S_RD1 && !r_out_valid) |=> r_out_valid, "read item not delivered")

endmodule
`default_nettype wire
